[rtl/ift_pkg.sv]
package ift_pkg;

   localparam int TABLE_ENTRIES = 16;
   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int LEN_W = 17;
   localparam int SLOT_W = 4;
   localparam logic [3:0] IPV4_VERSION = 4'd4;
   localparam logic [15:0] MAX_TOTAL_LEN_RESET = 16'd20480;
   localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

   typedef enum logic [2:0] {
      ST_PASS        = 3'd0,
      ST_OPENED      = 3'd1,
      ST_APPENDED    = 3'd2,
      ST_COMPLETE    = 3'd3,
      ST_TOO_LONG    = 3'd4,
      ST_UNSUPPORTED = 3'd5,
      ST_FULL        = 3'd6
   } status_type;

   typedef struct packed {
      logic [3:0]  ip_version;
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [15:0] frag_ident;
      logic        more_fragments;
      logic [12:0] frag_offset;
      logic [15:0] frag_len;
   } req_type;

   typedef struct packed {
      status_type        status;
      logic [LEN_W-1:0]  total_len;
      logic [SLOT_W-1:0] slot;
   } rsp_type;

   // low SLOT_W bits of an entry index, zero filled for small tables
   function automatic logic [SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] idx);
      logic [SLOT_W-1:0] s;
      s = '0;
      for (int b = 0; b < SLOT_W; b++) begin
         if (b < IDX_W) begin
            s[b] = idx[b];
         end
      end
      return s;
   endfunction

endpackage

[rtl/ift_req_if.sv]
interface ift_req_if;
   logic        valid;
   logic        ready;
   logic [3:0]  ip_version;
   logic [31:0] src_addr;
   logic [31:0] dst_addr;
   logic [15:0] frag_ident;
   logic        more_fragments;
   logic [12:0] frag_offset;
   logic [15:0] frag_len;

   modport source (output valid, ip_version, src_addr, dst_addr, frag_ident,
                   more_fragments, frag_offset, frag_len, input ready);
   modport sink (input valid, ip_version, src_addr, dst_addr, frag_ident,
                 more_fragments, frag_offset, frag_len, output ready);
endinterface

interface ift_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [2:0]                 status;
   logic [ift_pkg::LEN_W-1:0]  total_len;
   logic [ift_pkg::SLOT_W-1:0] slot;

   modport source (output valid, status, total_len, slot, input ready);
   modport sink (input valid, status, total_len, slot, output ready);
endinterface

[rtl/ipv4_fragment_tracker_top.sv]
// IPv4 fragment tracker.
// req_in carries one parsed fragment descriptor per item; rsp_out returns one
// result item (status, total_len, slot) for every accepted request item.
// csr_wr_en/csr_wr_data write max_total_len; write it only while idle.
// Datapath: request register -> table lookup/update -> result register.
// An accepted request item moves from the request register into the result
// register when that is empty or being drained. Throughput: one item per
// cycle when not stalled. The table lookup is a parallel key compare
// over all entries with lowest-index priority, and the table is updated at the
// same edge that loads the result register, so the next item sees it at once.
// Reset: all table entries are marked free, both registers empty and
// max_total_len returns to 20480. No clearing pass is needed.
// Stall: when rsp_out.ready is low the result register holds; the request
// register still takes one more item, then req_in.ready drops until the
// result moves on.
module ipv4_fragment_tracker_top (
   input  logic       clock,
   input  logic       reset,
   ift_req_if.sink    req_in,
   ift_rsp_if.source  rsp_out,
   input  logic       csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   logic             in_valid_ff;
   ift_pkg::req_type in_data_ff;
   logic             out_valid_ff;
   ift_pkg::rsp_type out_data_ff;
   logic [15:0]      max_len_ff;
   logic             advance;
   ift_pkg::rsp_type tbl_result;
   ift_pkg::req_type req_item;

   // pending item moves on when the result slot is empty or being drained
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_out.ready);
   assign req_in.ready = !in_valid_ff || advance;

   always_comb begin
      req_item.ip_version     = req_in.ip_version;
      req_item.src_addr       = req_in.src_addr;
      req_item.dst_addr       = req_in.dst_addr;
      req_item.frag_ident     = req_in.frag_ident;
      req_item.more_fragments = req_in.more_fragments;
      req_item.frag_offset    = req_in.frag_offset;
      req_item.frag_len       = req_in.frag_len;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= ift_pkg::MAX_TOTAL_LEN_RESET;
      end else if (csr_wr_en) begin
         max_len_ff <= csr_wr_data;
      end
   end

   // request register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_in.ready) begin
         in_valid_ff <= req_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_in.valid && req_in.ready) begin
         in_data_ff <= req_item;
      end
   end

   ift_table u_table (
      .clock         (clock),
      .reset         (reset),
      .upd_en        (advance),
      .item          (in_data_ff),
      .max_total_len (max_len_ff),
      .result        (tbl_result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_out.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= tbl_result;
      end
   end

   assign rsp_out.valid     = out_valid_ff;
   assign rsp_out.status    = out_data_ff.status;
   assign rsp_out.total_len = out_data_ff.total_len;
   assign rsp_out.slot      = out_data_ff.slot;

endmodule

[rtl/ift_table.sv]
module ift_table (
   input  logic             clock,
   input  logic             reset,
   input  logic             upd_en,
   input  ift_pkg::req_type item,
   input  logic [15:0]      max_total_len,
   output ift_pkg::rsp_type result
);

   localparam int N = ift_pkg::TABLE_ENTRIES;
   localparam int IW = ift_pkg::IDX_W;
   localparam int LW = ift_pkg::LEN_W;

   logic [N-1:0]  valid_ff;
   logic [N-1:0]  valid_in;
   logic [31:0]   src_ff   [N];
   logic [31:0]   dst_ff   [N];
   logic [15:0]   ident_ff [N];
   logic [LW-1:0] len_ff   [N];

   logic [N-1:0]  match;
   logic          hit;
   logic [IW-1:0] hit_idx;
   logic          has_free;
   logic [IW-1:0] free_idx;
   logic [LW:0]   sum_wide;
   logic [LW-1:0] sum;
   logic          open_en;
   logic          add_en;
   logic          free_en;

   // parallel key compare, lowest index wins
   always_comb begin
      hit      = 1'b0;
      hit_idx  = '0;
      has_free = 1'b0;
      free_idx = '0;
      for (int i = N - 1; i >= 0; i--) begin
         match[i] = valid_ff[i] && src_ff[i] == item.src_addr &&
                    dst_ff[i] == item.dst_addr && ident_ff[i] == item.frag_ident;
         if (match[i]) begin
            hit     = 1'b1;
            hit_idx = IW'(i);
         end
         if (!valid_ff[i]) begin
            has_free = 1'b1;
            free_idx = IW'(i);
         end
      end
   end

   always_comb begin
      sum_wide = {1'b0, len_ff[hit_idx]} + (LW + 1)'(item.frag_len);
      sum      = sum_wide[LW] ? ift_pkg::LEN_MAX : sum_wide[LW-1:0];
   end

   always_comb begin
      open_en  = 1'b0;
      add_en   = 1'b0;
      free_en  = 1'b0;
      result.status    = ift_pkg::ST_PASS;
      result.total_len = '0;
      result.slot      = '0;
      if (item.ip_version != ift_pkg::IPV4_VERSION) begin
         result.status = ift_pkg::ST_UNSUPPORTED;
      end else if (!item.more_fragments && item.frag_offset == '0) begin
         result.status    = ift_pkg::ST_PASS;
         result.total_len = LW'(item.frag_len);
      end else if (!hit) begin
         if (has_free) begin
            open_en          = 1'b1;
            result.status    = ift_pkg::ST_OPENED;
            result.total_len = LW'(item.frag_len);
            result.slot      = ift_pkg::to_slot(free_idx);
         end else begin
            result.status = ift_pkg::ST_FULL;
         end
      end else begin
         add_en           = 1'b1;
         result.total_len = sum;
         result.slot      = ift_pkg::to_slot(hit_idx);
         if (item.more_fragments) begin
            result.status = ift_pkg::ST_APPENDED;
         end else begin
            free_en = 1'b1;
            // oversize entries are freed too
            result.status = (sum > LW'(max_total_len)) ? ift_pkg::ST_TOO_LONG
                                                        : ift_pkg::ST_COMPLETE;
         end
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (upd_en && open_en) begin
         valid_in[free_idx] = 1'b1;
      end
      if (upd_en && free_en) begin
         valid_in[hit_idx] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (upd_en && open_en) begin
         src_ff[free_idx]   <= item.src_addr;
         dst_ff[free_idx]   <= item.dst_addr;
         ident_ff[free_idx] <= item.frag_ident;
         len_ff[free_idx]   <= LW'(item.frag_len);
      end
      if (upd_en && add_en) begin
         len_ff[hit_idx] <= sum;
      end
   end

endmodule
